// ----- rtl/rlev_pkg.sv -----
// rlev_pkg: types and constants shared by the run-length escape encoder
// used by rlev_front, rlev_queue, rlev_back and rle_escape_varint_encoder_core
// no dependencies
package rlev_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int LEN_W = 32;
  localparam int MAX_RESULTS = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] ESC_RESET = 8'd27;
  localparam logic [2:0] MIN_RUN_RESET = 3'd3;
  localparam logic [7:0] CNT2_MARK = 8'hfd;
  localparam logic [7:0] CNT4_MARK = 8'hfe;
  localparam logic [LEN_W-1:0] CNT2_LIMIT = 32'h0000_fffe;
  localparam logic [LEN_W-1:0] CNT1_LIMIT = 32'h0000_00fd;

  localparam logic CFG_ESCAPE = 1'b0;
  localparam logic CFG_MIN_RUN = 1'b1;

  // one entry per input item that gives output
  typedef struct packed {
    logic             last;
    logic             a_valid;
    logic [7:0]       a_value;
    logic [LEN_W-1:0] a_len;
    logic             b_valid;
    logic [7:0]       b_value;
  } flush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- rtl/rlev_front.sv -----
// rlev_front: tracks the open run and issues flush jobs
// depends on rlev_pkg
module rlev_front #(
  parameter int COUNT_BITS = rlev_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_accept,
  input  logic [7:0]      data_byte,
  input  logic            stream_last,
  output logic            push,
  output rlev_pkg::flush_t job,
  output logic            run_open
);
  import rlev_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [7:0]            run_value;
  logic [COUNT_BITS-1:0] run_length;
  logic [7:0]            run_value_next;
  logic [COUNT_BITS-1:0] run_length_next;
  logic [COUNT_BITS-1:0] len_inc;
  logic                  cont;

  assign len_inc = run_length + 1'b1;
  assign cont = (run_length != '0) && (data_byte == run_value);
  assign run_open = run_length != '0;

  always_comb begin
    run_value_next = run_value;
    run_length_next = run_length;
    push = 1'b0;
    job.last = stream_last;
    job.a_valid = 1'b0;
    job.a_value = run_value;
    job.a_len = LEN_W'(run_length);
    job.b_valid = 1'b0;
    job.b_value = data_byte;
    if (in_accept) begin
      if (cont) begin
        job.a_len = LEN_W'(len_inc);
        if (len_inc == COUNT_MAX || stream_last) begin
          push = 1'b1;
          job.a_valid = 1'b1;
          run_length_next = '0;
        end else begin
          run_length_next = len_inc;
        end
      end else begin
        job.a_valid = run_length != '0;
        run_value_next = data_byte;
        if (stream_last) begin
          job.b_valid = 1'b1;
          run_length_next = '0;
        end else begin
          run_length_next = COUNT_BITS'(1);
        end
        push = job.a_valid || stream_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value <= '0;
      run_length <= '0;
    end else begin
      run_value <= run_value_next;
      run_length <= run_length_next;
    end
  end

endmodule

// ----- rtl/rlev_queue.sv -----
// rlev_queue: short queue of flush jobs between front and back
// depends on rlev_pkg
module rlev_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rlev_pkg::flush_t       wr_job,
  input  logic                   pop,
  output rlev_pkg::flush_t       head,
  output rlev_pkg::queue_status_t status,
  output logic [$clog2(rlev_pkg::QUEUE_DEPTH+1)-1:0] count
);
  import rlev_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  flush_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign head = entries[rd_ptr];
  assign status.full = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/rlev_back.sv -----
// rlev_back: walks one flush job byte by byte into the output register
// depends on rlev_pkg
module rlev_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       escape_byte,
  input  logic [2:0]       min_run,
  input  logic             head_valid,
  input  rlev_pkg::flush_t head,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // code_byte
  output logic             m_tuser,   // item_last
  output logic             m_tlast    // stream_end
);
  import rlev_pkg::*;

  logic             b_phase;
  logic [3:0]       idx;
  logic [3:0]       cnt;
  logic             sel;
  logic [7:0]       cur_value;
  logic [LEN_W-1:0] cur_len;
  logic             is_code;
  logic             esc_lit;
  logic [3:0]       code_n;
  logic [3:0]       lit_n;
  logic [3:0]       nb;
  logic [7:0]       byte_out;
  logic [1:0]       len_sel;
  logic             run_end;
  logic             item_end;
  logic             load;

  assign sel = b_phase || !head.a_valid;
  assign cur_value = sel ? head.b_value : head.a_value;
  assign cur_len = sel ? LEN_W'(1) : head.a_len;
  assign is_code = cur_len >= LEN_W'(min_run);
  assign esc_lit = cur_value == escape_byte;
  assign lit_n = esc_lit ? {cur_len[2:0], 1'b0} : {1'b0, cur_len[2:0]};
  assign nb = is_code ? code_n : lit_n;
  assign len_sel = 2'(idx - 4'd2);

  always_comb begin
    if (cur_len < CNT1_LIMIT) begin
      code_n = 4'd3;
    end else if (cur_len <= CNT2_LIMIT) begin
      code_n = 4'd5;
    end else begin
      code_n = 4'd7;
    end
  end

  always_comb begin
    byte_out = cur_value;
    if (is_code) begin
      if (idx == 4'd0) begin
        byte_out = escape_byte;
      end else if (idx == nb - 4'd1) begin
        byte_out = cur_value;
      end else if (code_n == 4'd3) begin
        byte_out = cur_len[7:0];
      end else if (idx == 4'd1) begin
        byte_out = (code_n == 4'd5) ? CNT2_MARK : CNT4_MARK;
      end else begin
        case (len_sel)
          2'd0: byte_out = cur_len[7:0];
          2'd1: byte_out = cur_len[15:8];
          2'd2: byte_out = cur_len[23:16];
          2'd3: byte_out = cur_len[31:24];
          default: byte_out = cur_len[7:0];
        endcase
      end
    end else if (esc_lit && idx[0]) begin
      byte_out = 8'h00;
    end
  end

  assign run_end = idx == nb - 4'd1;
  assign item_end = (run_end && (sel || !head.b_valid)) || (cnt == 4'(MAX_RESULTS - 1));
  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop = load && item_end;

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_out;
      m_tuser <= item_end;
      m_tlast <= item_end && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      b_phase <= 1'b0;
      idx <= '0;
      cnt <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        if (item_end) begin
          b_phase <= 1'b0;
          idx <= '0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 4'd1;
          if (run_end) begin
            b_phase <= 1'b1;
            idx <= '0;
          end else begin
            idx <= idx + 4'd1;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/rle_escape_varint_encoder_core.sv -----
// rle_escape_varint_encoder_core: top level of the run-length escape encoder
// depends on rlev_pkg, rlev_front, rlev_queue, rlev_back
//
// Takes one raw byte per cycle on the slave stream while the flush queue is not full and
// emits the encoded bytes on the master stream. The front tracks the open run and posts
// a flush job to a two-entry queue whenever a run closes; the back turns each job
// into 1 to 14 output bytes, one byte per cycle while the master stream is not stalled,
// into a registered output stage. Bytes that only extend a run give no output, and the
// slave side stalls only once both queue entries are waiting. A closing byte's job is
// written into the queue before the back registers its first output byte. No clearing
// pass after reset.
module rle_escape_varint_encoder_core #(
  parameter int COUNT_BITS = rlev_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,   // stream_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // code_byte
  output logic       m_tuser,   // item_last
  output logic       m_tlast,   // stream_end
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata
);
  import rlev_pkg::*;

  logic [7:0]    escape_reg;
  logic [2:0]    min_run;
  logic          in_accept;
  logic          push;
  logic          pop;
  logic          run_open;
  flush_t        job;
  flush_t        head;
  queue_status_t q_status;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign s_tready = !q_status.full;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_reg <= ESC_RESET;
      min_run <= MIN_RUN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ESCAPE: escape_reg <= cfg_wdata;
        CFG_MIN_RUN: min_run <= cfg_wdata[2:0];
        default: escape_reg <= escape_reg;
      endcase
    end
  end

  rlev_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_accept(in_accept),
    .data_byte(s_tdata),
    .stream_last(s_tlast),
    .push(push),
    .job(job),
    .run_open(run_open)
  );

  rlev_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_job(job),
    .pop(pop),
    .head(head),
    .status(q_status),
    .count(q_count)
  );

  rlev_back u_back (
    .clk(clk),
    .rst(rst),
    .escape_byte(escape_reg),
    .min_run(min_run),
    .head_valid(!q_status.empty),
    .head(head),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full || pop)
    else $error("flush queue overflow");

  a_last_closes_run: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tlast |=> !run_open)
    else $error("run left open after final byte");

  a_end_is_item_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("stream end not on final byte of an item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- sim/rlev_encode_checker.sv -----
// rlev_encode_checker: watches both streams and the register port of the encoder,
// predicts the code bytes of every accepted raw byte and compares them in order
// depends on rlev_pkg
`timescale 1ns / 100ps

module rlev_encode_checker #(
  parameter int COUNT_BITS = rlev_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tuser,
  input  logic       m_tlast,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata,
  output int         errors,
  output int         codes_due
);
  import rlev_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       item_last;
    logic       stream_end;
  } code_t;

  localparam logic [LEN_W-1:0] RUN_MAX = LEN_W'((64'd1 << COUNT_BITS) - 64'd1);

  logic [7:0]       esc_val;
  logic [2:0]       min_len;
  logic [7:0]       run_val;
  logic [LEN_W-1:0] run_len;
  code_t            code_q[$];
  int               step_codes;

  initial begin
    errors = 0;
    codes_due = 0;
  end

  task automatic put_code(input logic [7:0] b);
    code_t c;
    c.code = b;
    c.item_last = 1'b0;
    c.stream_end = 1'b0;
    code_q.push_back(c);
    step_codes++;
  endtask

  task automatic close_run();
    logic [LEN_W-1:0] n;
    int i;
    n = run_len;
    if (n != 0) begin
      if (n < LEN_W'(min_len)) begin
        for (i = 0; i < n; i++) begin
          put_code(run_val);
          if (run_val == esc_val) put_code(8'h00);
        end
      end else begin
        put_code(esc_val);
        if (n < CNT1_LIMIT) begin
          put_code(n[7:0]);
        end else if (n <= CNT2_LIMIT) begin
          put_code(CNT2_MARK);
          put_code(n[7:0]);
          put_code(n[15:8]);
        end else begin
          put_code(CNT4_MARK);
          put_code(n[7:0]);
          put_code(n[15:8]);
          put_code(n[23:16]);
          put_code(n[31:24]);
        end
        put_code(run_val);
      end
      run_len = '0;
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    code_t c;
    step_codes = 0;
    if (run_len != 0 && b == run_val) begin
      run_len = run_len + 1'b1;
      if (run_len >= RUN_MAX) close_run();
    end else begin
      close_run();
      run_val = b;
      run_len = 1;
    end
    if (last) close_run();
    if (step_codes > 0) begin
      c = code_q.pop_back();
      c.item_last = 1'b1;
      c.stream_end = last;
      code_q.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    code_t want;
    if (rst) begin
      esc_val = ESC_RESET;
      min_len = MIN_RUN_RESET;
      run_val = '0;
      run_len = '0;
      code_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_ESCAPE) esc_val = cfg_wdata;
        else min_len = cfg_wdata[2:0];
      end
      if (s_tvalid && s_tready) encode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (code_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected code byte %02h item_last %0b stream_end %0b",
                     $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = code_q.pop_front();
          if (want !== {m_tdata, m_tuser, m_tlast}) begin
            errors++;
            if (errors <= 10)
              $display("%0t: code mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       $time, want.code, want.item_last, want.stream_end,
                       m_tdata, m_tuser, m_tlast);
          end
        end
      end
    end
    codes_due = code_q.size();
  end

endmodule

// ----- sim/tb.sv -----
// tb: regression bench for rle_escape_varint_encoder_core with directed, long-run
// and random byte streams under random idling on both streams
// depends on rlev_pkg, rle_escape_varint_encoder_core and rlev_encode_checker
`timescale 1ns / 100ps

module tb;
  import rlev_pkg::*;

  // run counter width of the block under test
  localparam int CNT_BITS = 16;
  localparam int WATCH_LIMIT = 4000;
  localparam int SETTLE = 16;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // data_byte
  logic       s_tlast;   // stream_last
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // code_byte
  logic       m_tuser;   // item_last
  logic       m_tlast;   // stream_end
  logic       cfg_we;
  logic       cfg_addr;
  logic [7:0] cfg_wdata;

  int         errors;
  int         codes_due;
  int         idle_cycles = 0;
  int         sent = 0;
  int         gap_odds;
  bit         quiet;
  bit         calm;
  logic [7:0] cur_esc;
  logic [2:0] cur_min;

  rle_escape_varint_encoder_core #(.COUNT_BITS(CNT_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  rlev_encode_checker #(.COUNT_BITS(CNT_BITS)) chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .codes_due(codes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet || calm) begin
        m_tready = 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else if ($urandom_range(0, 9) == 0) begin
        m_tready = 1'b0;
        hold = $urandom_range(0, 12);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCH_LIMIT) begin
      $display("rle_escape_varint_encoder_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    if (!quiet && !calm && $urandom_range(0, gap_odds) == 0) begin
      s_tvalid = 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (l) s_tvalid = 1'b0;
    sent++;
  endtask

  task automatic send_run(input logic [7:0] v, input int len, input bit fin);
    int i;
    for (i = 0; i < len; i++) send_byte(v, fin && i == len - 1);
  endtask

  task automatic drain();
    while (codes_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] e, input logic [2:0] m);
    write_reg(CFG_ESCAPE, e);
    write_reg(CFG_MIN_RUN, {5'($urandom), m});
    cur_esc = e;
    cur_min = m;
  endtask

  // runs of mixed lengths, some streams plain noise; ends on stream_last
  task automatic send_stream(input int n);
    int left, k, len;
    logic [7:0] v;
    bit noise;
    calm = ($urandom_range(0, 3) == 0);
    noise = ($urandom_range(0, 4) == 0);
    left = n;
    while (left > 0) begin
      if (noise) begin
        v = 8'($urandom);
        len = 1;
      end else begin
        case ($urandom_range(0, 3))
          0: v = cur_esc;
          1: v = $urandom_range(0, 1) ? 8'hff : 8'h00;
          default: v = 8'($urandom);
        endcase
        k = $urandom_range(0, 99);
        if (k < 70) len = $urandom_range(1, cur_min + 2);
        else if (k < 97) len = $urandom_range(1, 20);
        else len = $urandom_range(250, 270);
      end
      if (len > left) len = left;
      send_run(v, len, len >= left);
      left -= len;
    end
    calm = 1'b0;
  endtask

  task automatic random_phase(input logic [7:0] e, input logic [2:0] m, input int target);
    int start, left;
    set_config(e, m);
    start = sent;
    left = target;
    while (left > 0) begin
      send_stream($urandom_range(1, (left < 40) ? left : 40));
      left = target - (sent - start);
    end
  endtask

  initial begin
    logic [7:0] v;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_ESCAPE;
    cfg_wdata = '0;
    quiet = 1'b0;
    calm = 1'b0;
    gap_odds = 6;
    cur_esc = ESC_RESET;
    cur_min = MIN_RUN_RESET;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // reset settings: lone bytes, short literals, escape literal, run codes
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(ESC_RESET, 1'b1);
    send_run(ESC_RESET, 3, 1'b1);
    send_run(8'h05, 4, 1'b0);
    send_byte(8'h06, 1'b1);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b1);
    send_run(ESC_RESET, 2, 1'b0);
    send_run(8'h80, 2, 1'b1);

    // long run: shortest run that takes the two-byte count
    gap_odds = 200;
    set_config(8'($urandom_range(1, 255)), 3'd7);
    v = 8'($urandom);
    send_run(v, 253, 1'b1);
    gap_odds = 6;

    random_phase(8'h00, 3'd0, 20);
    random_phase(8'hff, 3'd7, 20);
    random_phase(8'h01, 3'd1, 20);
    random_phase(8'($urandom_range(1, 255)), 3'($urandom_range(1, 7)), 20);
    random_phase(8'($urandom), 3'($urandom), 20);
    random_phase(ESC_RESET, MIN_RUN_RESET, 20);
    quiet = 1'b1;
    random_phase(8'($urandom_range(1, 255)), 3'($urandom_range(1, 7)), 20);

    drain();
    if (errors == 0 && codes_due == 0) begin
      $display("rle_escape_varint_encoder_core regression: pass");
    end else begin
      $display("rle_escape_varint_encoder_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rlev_pkg.sv
rtl/rlev_front.sv
rtl/rlev_queue.sv
rtl/rlev_back.sv
rtl/rle_escape_varint_encoder_core.sv
sim/rlev_encode_checker.sv
sim/tb.sv
